>>> hdl/ctse_pkg.sv
`timescale 1ns / 1ps
package ctse_pkg;

  // fixed sizes of the synthesizer
  localparam int PHASE_BITS        = 32;
  localparam int SINE_DEPTH        = 1024;
  localparam int DECAY_DEPTH       = 256;
  localparam int SINE_AW           = $clog2(SINE_DEPTH);
  localparam int DECAY_AW          = $clog2(DECAY_DEPTH);
  localparam int SAMPLE_RATE       = 44100;
  localparam int RAMP_FRAC_BITS    = 16;
  localparam int SAMPLE_LIMIT      = 32000;
  localparam int GAIN_MAX          = 100;

  // shared divider sizes
  localparam int DIV_W             = 32;
  localparam int DIV_CW            = 6;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_MULA   = 4'd2;
  localparam logic [3:0] OP_MULB   = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_PHASE  = 4'd5;
  localparam logic [3:0] OP_SINE   = 4'd6;
  localparam logic [3:0] OP_RAMP   = 4'd7;
  localparam logic [3:0] OP_DECAY  = 4'd8;
  localparam logic [3:0] OP_M1     = 4'd9;
  localparam logic [3:0] OP_M2     = 4'd10;
  localparam logic [3:0] OP_M3     = 4'd11;
  localparam logic [3:0] OP_M4     = 4'd12;
  localparam logic [3:0] OP_RESULT = 4'd13;

  // divider operand selection
  localparam logic [1:0] DSEL_INC   = 2'd0;
  localparam logic [1:0] DSEL_RAMP  = 2'd1;
  localparam logic [1:0] DSEL_DECAY = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] div_sel;
  } ctse_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic seg_active;
    logic in_ramp;
    logic out_full;
  } ctse_status_t;

  typedef logic [15:0] sine_rom_t [SINE_DEPTH];
  typedef logic [15:0] decay_rom_t [DECAY_DEPTH];

  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // sin of a Q30 angle in the first quadrant, Q30 result
  function automatic logic [63:0] sin_q30(logic [63:0] a);
    logic [63:0] term;
    logic [63:0] sum;
    term = a;
    sum  = a;
    for (int n = 1; n <= 7; n++) begin
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  // exp(-y) for Q30 y below 4, Q30 result
  function automatic logic [63:0] exp_neg_q30(logic [63:0] y);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    z    = y >> 4;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * z) >> 30) / 64'(n);
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    for (int k = 0; k < 4; k++) sum = (sum * sum) >> 30;
    return sum;
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] f;
    logic [63:0] v;
    logic        neg;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      f   = (64'(k) << 32) / SINE_DEPTH;
      neg = 1'b0;
      if (f >= (64'd1 << 31)) begin
        neg = 1'b1;
        f   = f - (64'd1 << 31);
      end
      if (f > (64'd1 << 30)) f = (64'd1 << 31) - f;
      v = (sin_q30((f * TWO_PI_Q30) >> 32) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      rom[k] = neg ? 16'(-v) : v[15:0];
    end
    return rom;
  endfunction

  function automatic decay_rom_t build_decay();
    decay_rom_t  rom;
    logic [63:0] y;
    logic [63:0] v;
    for (int k = 0; k < DECAY_DEPTH; k++) begin
      y = (64'(4 * k) << 30) / DECAY_DEPTH;
      v = (exp_neg_q30(y) * 64'd65535 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd65535) v = 64'd65535;
      rom[k] = v[15:0];
    end
    return rom;
  endfunction

endpackage

>>> hdl/chirp_tone_envelope_synth_unit.sv
`timescale 1ns / 1ps
// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     tdata: segment fields, tuser: kind
// out_     out  out_tvalid / out_tready   tdata: sample, tlast: last, tuser: active
// cfg_     in   cfg_wr_en                 cfg_wr_data: volume_percent
//
// a load request is taken in the idle state; an idle tick goes through the result state only
// an active tick runs the multiplies, the increment division, sine, the envelope division and gain;
// the one-bit-per-cycle divider is shared by the increment and envelope divisions
// rst_n is synchronous; sine and decay tables are constants, no clearing pass
// a result waits in the output register; a tick stalls only if it is still full
module chirp_tone_envelope_synth_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [14:0] start_freq_hz, [29:15] end_freq_hz, [45:30] length_samples,
  // [55:46] level, [67:56] attack_samples, [71:68] zero
  input  logic [71:0] in_tdata,
  // [0] kind
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] sample
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  // [0] active
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);
  import ctse_pkg::*;

  ctse_cmd_t    cmd;
  ctse_status_t status;

  ctse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  ctse_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

>>> hdl/ctse_div.sv
`timescale 1ns / 1ps
module ctse_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ctse_pkg::DIV_W-1:0]  rem_init,
  input  logic [ctse_pkg::DIV_W-1:0]  bits_in,
  input  logic [ctse_pkg::DIV_W-1:0]  divisor,
  input  logic [ctse_pkg::DIV_CW-1:0] iters,
  output logic                        busy,
  output logic [ctse_pkg::DIV_W-1:0]  quot
);
  import ctse_pkg::*;

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  bits_r, bits_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [DIV_W-1:0]  quot_r, quot_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_W:0]    trial;
  logic              fits;

  // one restoring step per cycle, dividend bits enter msb first
  always_comb begin
    trial    = {rem_r, bits_r[DIV_W-1]};
    fits     = trial >= {1'b0, div_r};
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    div_nxt  = div_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      rem_nxt  = rem_init;
      bits_nxt = bits_in;
      div_nxt  = divisor;
      quot_nxt = '0;
      cnt_nxt  = iters;
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
      bits_nxt = {bits_r[DIV_W-2:0], 1'b0};
      quot_nxt = {quot_r[DIV_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    div_r  <= div_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = cnt_r != '0;
  assign quot = quot_r;

endmodule

>>> hdl/ctse_datapath.sv
`timescale 1ns / 1ps
module ctse_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctse_pkg::ctse_cmd_t  cmd,
  output ctse_pkg::ctse_status_t status,
  input  logic [71:0]          in_tdata,
  input  logic                 cfg_wr_en,
  input  logic [6:0]           cfg_wr_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser
);
  import ctse_pkg::*;

  localparam sine_rom_t  SINE_ROM  = build_sine();
  localparam decay_rom_t DECAY_ROM = build_decay();

  // segment state
  logic [PHASE_BITS-1:0] phase_acc_r;
  logic [15:0]           sample_index_r;
  logic [15:0]           seg_length_r;
  logic [11:0]           seg_attack_r;
  logic [14:0]           seg_start_freq_r;
  logic [14:0]           seg_end_freq_r;
  logic [9:0]            seg_level_r;
  logic                  segment_active_r;
  logic [6:0]            volume_r;

  // work registers
  logic [30:0]           p1_r;
  logic [31:0]           den_r;
  logic [30:0]           num_r;
  logic [15:0]           sine_r;
  logic [16:0]           env_r;
  logic [31:0]           m1_r;
  logic [41:0]           m2_r;
  logic [48:0]           m3_r;
  logic [57:0]           m4_r;

  logic [15:0]           out_sample_r;
  logic                  out_last_r;
  logic                  out_active_r;
  logic                  out_valid_r;

  // divider operands
  logic [DIV_W-1:0]      d_rem, d_bits, d_div, quot;
  logic [DIV_CW-1:0]     d_iters;
  logic                  div_busy;

  logic [15:0]           in_len;
  logic [15:0]           s_abs;
  logic [6:0]            gain;
  logic [16:0]           idx_inc;
  logic                  last;
  logic [14:0]           fq_hi;
  logic [14:0]           fq_lo;
  logic [15:0]           fq_sum;
  logic [15:0]           fq_quot;
  logic [14:0]           mag;

  assign in_len = in_tdata[45:30];
  assign s_abs  = sine_r[15] ? 16'(-sine_r) : sine_r;
  assign gain   = (volume_r > 7'(GAIN_MAX)) ? 7'(GAIN_MAX) : volume_r;
  assign idx_inc = {1'b0, sample_index_r} + 17'd1;
  assign last    = idx_inc == {1'b0, seg_length_r};

  // scaled product over 2^26 is below 2^30; divide it by 2^15-1 by folding
  assign fq_hi   = m4_r[55:41];
  assign fq_lo   = m4_r[40:26];
  assign fq_sum  = {1'b0, fq_hi} + {1'b0, fq_lo};
  assign fq_quot = {1'b0, fq_hi} + 16'(fq_sum >= 16'd32767) + 16'(fq_sum >= 16'd65534);
  assign mag     = (fq_quot > 16'(SAMPLE_LIMIT)) ? 15'(SAMPLE_LIMIT) : fq_quot[14:0];

  // operand select for the shared divider
  always_comb begin
    d_rem   = '0;
    d_bits  = '0;
    d_div   = den_r;
    d_iters = DIV_CW'(PHASE_BITS);
    case (cmd.div_sel)
      DSEL_INC: begin
        d_rem   = DIV_W'(num_r);
        d_div   = den_r;
        d_iters = DIV_CW'(PHASE_BITS);
      end
      DSEL_RAMP: begin
        d_rem   = DIV_W'(sample_index_r);
        d_div   = DIV_W'(seg_attack_r);
        d_iters = DIV_CW'(RAMP_FRAC_BITS);
      end
      DSEL_DECAY: begin
        d_rem   = DIV_W'(sample_index_r - 16'(seg_attack_r));
        d_div   = DIV_W'(seg_length_r - 16'(seg_attack_r));
        d_iters = DIV_CW'(DECAY_AW);
      end
      default: ;
    endcase
  end

  ctse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_DIV),
    .rem_init (d_rem),
    .bits_in  (d_bits),
    .divisor  (d_div),
    .iters    (d_iters),
    .busy     (div_busy),
    .quot     (quot)
  );

  // control state: segment flags and fields, counters, phase, gain, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_active_r <= 1'b0;
      sample_index_r   <= '0;
      phase_acc_r      <= '0;
      seg_length_r     <= '0;
      seg_attack_r     <= '0;
      seg_start_freq_r <= '0;
      seg_end_freq_r   <= '0;
      seg_level_r      <= '0;
      volume_r         <= 7'(GAIN_MAX);
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) volume_r <= cfg_wr_data;
      if (cmd.op == OP_RESULT) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          if (in_len != '0) begin
            seg_start_freq_r <= in_tdata[14:0];
            seg_end_freq_r   <= in_tdata[29:15];
            seg_length_r     <= in_len;
            seg_level_r      <= in_tdata[55:46];
            seg_attack_r     <= in_tdata[67:56];
            sample_index_r   <= '0;
            phase_acc_r      <= '0;
            segment_active_r <= 1'b1;
          end
        end
        OP_PHASE: phase_acc_r <= phase_acc_r + quot;
        OP_RESULT: begin
          if (segment_active_r) begin
            sample_index_r <= idx_inc[15:0];
            if (last) segment_active_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic steps of one sample
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MULA: begin
        p1_r  <= 31'(seg_start_freq_r * (seg_length_r - sample_index_r));
        den_r <= 32'(seg_length_r * 16'(SAMPLE_RATE));
      end
      OP_MULB:  num_r  <= p1_r + 31'(seg_end_freq_r * sample_index_r);
      OP_SINE:  sine_r <= SINE_ROM[phase_acc_r[PHASE_BITS-1 -: SINE_AW]];
      OP_RAMP:  env_r  <= {1'b0, quot[15:0]};
      OP_DECAY: env_r  <= {1'b0, DECAY_ROM[quot[DECAY_AW-1:0]]};
      OP_M1:    m1_r   <= 32'(s_abs[14:0] * env_r);
      OP_M2:    m2_r   <= 42'(m1_r * seg_level_r);
      OP_M3:    m3_r   <= 49'(m2_r * gain);
      OP_M4:    m4_r   <= 58'({m3_r, 8'b0}) + 58'({m3_r, 6'b0});
      OP_RESULT: begin
        if (segment_active_r) begin
          out_sample_r <= sine_r[15] ? 16'(-{1'b0, mag}) : {1'b0, mag};
          out_last_r   <= last;
          out_active_r <= 1'b1;
        end else begin
          out_sample_r <= '0;
          out_last_r   <= 1'b0;
          out_active_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign status.div_busy   = div_busy;
  assign status.seg_active = segment_active_r;
  assign status.in_ramp    = sample_index_r < 16'(seg_attack_r);
  assign status.out_full   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_active_r;

endmodule

>>> hdl/ctse_ctrl.sv
`timescale 1ns / 1ps
module ctse_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,
  input  ctse_pkg::ctse_status_t status,
  output ctse_pkg::ctse_cmd_t    cmd
);
  import ctse_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MULA = 5'd1;
  localparam logic [4:0] S_MULB = 5'd2;
  localparam logic [4:0] S_DIVI = 5'd3;
  localparam logic [4:0] S_WDI  = 5'd4;
  localparam logic [4:0] S_PH   = 5'd5;
  localparam logic [4:0] S_SN   = 5'd6;
  localparam logic [4:0] S_EV   = 5'd7;
  localparam logic [4:0] S_WDE  = 5'd8;
  localparam logic [4:0] S_ENV  = 5'd9;
  localparam logic [4:0] S_M1   = 5'd10;
  localparam logic [4:0] S_M2   = 5'd11;
  localparam logic [4:0] S_M3   = 5'd12;
  localparam logic [4:0] S_M4   = 5'd13;
  localparam logic [4:0] S_RES  = 5'd16;

  logic [4:0] state_r, state_nxt;

  assign in_tready = state_r == S_IDLE;

  // sequencing of one sample
  always_comb begin
    state_nxt   = state_r;
    cmd.op      = OP_NONE;
    cmd.div_sel = DSEL_INC;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!in_tuser) cmd.op = OP_LOAD;
          else state_nxt = status.seg_active ? S_MULA : S_RES;
        end
      end
      S_MULA: begin
        cmd.op    = OP_MULA;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.op    = OP_MULB;
        state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.op    = OP_DIV;
        state_nxt = S_WDI;
      end
      S_WDI: if (!status.div_busy) state_nxt = S_PH;
      S_PH: begin
        cmd.op    = OP_PHASE;
        state_nxt = S_SN;
      end
      S_SN: begin
        cmd.op    = OP_SINE;
        state_nxt = S_EV;
      end
      S_EV: begin
        cmd.op      = OP_DIV;
        cmd.div_sel = status.in_ramp ? DSEL_RAMP : DSEL_DECAY;
        state_nxt   = S_WDE;
      end
      S_WDE: if (!status.div_busy) state_nxt = S_ENV;
      S_ENV: begin
        cmd.op    = status.in_ramp ? OP_RAMP : OP_DECAY;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.op    = OP_M3;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.op    = OP_M4;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!status.out_full) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/ctse_checker.sv
`timescale 1ns / 1ps
module ctse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // idle ticks give silence and no end mark
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 16'd0 && !out_tlast)
    else $error("idle result not silent");

  // end of segment only on a segment sample
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("end mark without active segment");

  // saturation bound
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= 16'sd32000) && ($signed(out_tdata) >= -16'sd32000))
    else $error("sample out of range");

endmodule

bind chirp_tone_envelope_synth_unit ctse_checker u_ctse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

>>> tb/sv/chirp_tone_envelope_synth_unit_tb.sv
`timescale 1ns / 1ps
module chirp_tone_envelope_synth_unit_tb;
  import ctse_pkg::*;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam int   IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        kind;
    logic [14:0] f0;
    logic [14:0] f1;
    logic [15:0] len;
    logic [9:0]  lvl;
    logic [11:0] att;
  } tone_req_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        active;
  } tone_smp_t;

  // directed row: request, whether a typed expectation applies, and that expectation
  typedef struct packed {
    tone_req_t req;
    logic      typed;
    tone_smp_t smp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;

  chirp_tone_envelope_synth_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // synth model state
  logic [15:0] sine_lut [SINE_DEPTH];
  logic [15:0] decay_lut [DECAY_DEPTH];
  logic [6:0]  gain_reg;
  logic [31:0] phase;
  logic [15:0] idx;
  tone_req_t   seg;
  logic        running;

  tone_smp_t   sample_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          reqs_sent = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // table generation mirrors the exact integer procedure
  function automatic logic [63:0] tay_sin(logic [63:0] a);
    logic [63:0] t;
    logic [63:0] s;
    t = a;
    s = a;
    for (int n = 1; n <= 7; n++) begin
      t = (t * a) >> 30;
      t = (t * a) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - t;
      else s = s + t;
    end
    return s;
  endfunction

  function automatic logic [63:0] tay_exp(logic [63:0] y);
    logic [63:0] z;
    logic [63:0] t;
    logic [63:0] s;
    z = y >> 4;
    t = 64'd1 << 30;
    s = 64'd1 << 30;
    for (int n = 1; n <= 8; n++) begin
      t = ((t * z) >> 30) / 64'(n);
      if (n % 2 == 1) s = s - t;
      else s = s + t;
    end
    for (int k = 0; k < 4; k++) s = (s * s) >> 30;
    return s;
  endfunction

  task automatic fill_luts();
    logic [63:0] f;
    logic [63:0] v;
    logic        neg;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      f = (64'(k) << 32) / SINE_DEPTH;
      neg = 1'b0;
      if (f >= (64'd1 << 31)) begin
        neg = 1'b1;
        f = f - (64'd1 << 31);
      end
      if (f > (64'd1 << 30)) f = (64'd1 << 31) - f;
      v = (tay_sin((f * 64'd6746518852) >> 32) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      sine_lut[k] = neg ? 16'(-v) : v[15:0];
    end
    for (int k = 0; k < DECAY_DEPTH; k++) begin
      f = (64'(4 * k) << 30) / DECAY_DEPTH;
      v = (tay_exp(f) * 64'd65535 + (64'd1 << 29)) >> 30;
      if (v > 64'd65535) v = 64'd65535;
      decay_lut[k] = v[15:0];
    end
  endtask

  // advance the synth by one request; returns 1 when a sample results
  function automatic bit synth_step(input tone_req_t r, output tone_smp_t o);
    logic [63:0] i;
    logic [63:0] l;
    logic [63:0] a;
    logic [63:0] num;
    logic [63:0] inc;
    logic [63:0] env;
    logic [63:0] g;
    logic [63:0] mag;
    logic [127:0] prod;
    logic signed [15:0] sv;
    logic [15:0] res;
    o = '0;
    if (r.kind == KIND_LOAD) begin
      if (r.len == 0) return 0;
      seg = r;
      idx = '0;
      phase = '0;
      running = 1'b1;
      return 0;
    end
    if (!running || idx >= seg.len) begin
      running = 1'b0;
      return 1;
    end
    i = 64'(idx);
    l = 64'(seg.len);
    a = 64'(seg.att);
    num = 64'(seg.f0) * (l - i) + 64'(seg.f1) * i;
    inc = (num << 32) / (l * 64'(SAMPLE_RATE));
    phase = phase + inc[31:0];
    sv = $signed(sine_lut[phase[31:22]]);
    if (i < a) env = (i << 16) / a;
    else env = 64'(decay_lut[8'((((i - a) * 64'(DECAY_DEPTH)) / (l - a)))]);
    g = (gain_reg > 7'd100) ? 64'd100 : 64'(gain_reg);
    prod = 128'(sv < 0 ? -64'(sv) : 64'(sv)) * env * 64'(seg.lvl) * g * 128'd32000;
    mag = 64'(prod / (128'd32767 * 128'd65536 * 128'd1024 * 128'd100));
    if (mag > 64'd32000) mag = 64'd32000;
    res = (sv < 0) ? 16'(-mag) : mag[15:0];
    o.sample = res;
    o.last = (i + 1 == l);
    o.active = 1'b1;
    idx = idx + 16'd1;
    if (o.last) running = 1'b0;
    return 1;
  endfunction

  // send one request and queue the predicted sample
  task automatic send_req(input tone_req_t r, input bit typed, input tone_smp_t want);
    tone_smp_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = r.kind;
    in_tdata  = {4'b0, r.att, r.lvl, r.len, r.f1, r.f0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (synth_step(r, p)) begin
      if (typed && p != want)
        $display("note: typed expectation %h differs from model %h", want, p);
      if (typed) p = want;
      sample_q.insert(sample_q.size(), p);
    end
    reqs_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_gain(input logic [6:0] v);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    gain_reg = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic tone_req_t load_req(int f0, int f1, int len, int lvl, int att);
    tone_req_t r;
    r.kind = KIND_LOAD;
    r.f0 = 15'(f0);
    r.f1 = 15'(f1);
    r.len = 16'(len);
    r.lvl = 10'(lvl);
    r.att = 12'(att);
    return r;
  endfunction

  function automatic tone_req_t tick_req();
    tone_req_t r;
    r = tone_req_t'({$urandom, $urandom, $urandom});
    r.kind = KIND_TICK;
    return r;
  endfunction

  // receiver side: random stalls, compare against the oldest prediction
  always @(negedge clk)
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    tone_smp_t got;
    tone_smp_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL chirp_tone_envelope_synth_unit");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tlast, out_tuser};
        results_seen++;
        if (sample_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected sample %h", got);
        end else begin
          want = sample_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: sample %h/%h last %b/%b active %b/%b",
                       want.sample, got.sample, want.last, got.last,
                       want.active, got.active);
          end
        end
      end
    end
  end

  // directed table: idle tick, extremes, short and single-sample segments
  dir_row_t dir_tab [$];

  task automatic add_row(input tone_req_t req, input bit typed, input tone_smp_t smp);
    dir_row_t row;
    row.req = req;
    row.typed = typed;
    row.smp = smp;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  task automatic run_random(int n);
    tone_req_t r;
    int left;
    for (int k = 0; k < n; ) begin
      if ($urandom_range(9) == 0) begin
        r = tone_req_t'({$urandom, $urandom, $urandom});
        r.kind = 1'($urandom_range(1));
        if (r.kind == KIND_LOAD && $urandom_range(3) == 0) r.len = '0;
        send_req(r, 0, '0);
        k++;
      end else begin
        // well-formed segment: load then its ticks, sometimes cut or overrun
        left = $urandom_range(1, 24);
        r = load_req($urandom_range(22050), $urandom_range(22050),
                     ($urandom_range(7) == 0) ? $urandom_range(65535) : left,
                     $urandom_range(1023), $urandom_range(4095));
        if ($urandom_range(2) == 0) r.att = 12'($urandom_range(left));
        send_req(r, 0, '0);
        k++;
        left = left + $urandom_range(2) - 1;
        for (int j = 0; j < left && k < n; j++) begin
          send_req(tick_req(), 0, '0);
          k++;
        end
      end
    end
  endtask

  initial begin
    tone_smp_t z;
    z = '0;
    fill_luts();
    gain_reg = 7'd100;
    phase = '0;
    idx = '0;
    seg = '0;
    running = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    add_row(tick_req(), 1'b1, z);
    add_row(load_req(22050, 0, 4, 1023, 0), 1'b0, z);
    for (int k = 0; k < 4; k++) add_row(tick_req(), 1'b0, z);
    add_row(tick_req(), 1'b1, z);
    add_row(load_req(0, 22050, 1, 1023, 4095), 1'b0, z);
    add_row(tick_req(), 1'b1, tone_smp_t'({16'd0, 1'b1, 1'b1}));
    add_row(load_req(32767, 32767, 6, 1023, 2), 1'b0, z);
    add_row(tick_req(), 1'b0, z);
    add_row(tick_req(), 1'b0, z);
    add_row(load_req(1000, 1000, 0, 1023, 0), 1'b0, z);
    add_row(tick_req(), 1'b0, z);
    add_row(load_req(11025, 11025, 65535, 0, 0), 1'b0, z);
    add_row(tick_req(), 1'b0, z);
    add_row(load_req(5000, 300, 3, 1023, 0), 1'b0, z);
    for (int k = 0; k < 3; k++) add_row(tick_req(), 1'b0, z);
    foreach (dir_tab[k]) send_req(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].smp);
    drain();

    // gain settings including mute, full and the clamped range above 100
    write_gain(7'd0);
    send_req(load_req(3000, 9000, 3, 1023, 1), 0, '0);
    repeat (3) send_req(tick_req(), 0, '0);
    drain();
    write_gain(7'd127);
    run_random(360);
    drain();

    write_gain(7'd55);
    send_idle_pct = 46;
    run_random(360);
    drain();

    write_gain(7'd100);
    send_idle_pct = 0;
    recv_stall_pct = 46;
    run_random(360);
    drain();

    write_gain(7'($urandom_range(127)));
    send_idle_pct = 11;
    recv_stall_pct = 11;
    run_random(340);
    drain();

    $display("covered %0d requests and %0d samples over gains 0, 55, 100, 127 and random",
             reqs_sent, results_seen);
    if (errors == 0 && sample_q.size() == 0) begin
      $display("PASS chirp_tone_envelope_synth_unit");
    end else begin
      $display("errors %0d, samples still expected %0d", errors, sample_q.size());
      $display("FAIL chirp_tone_envelope_synth_unit");
    end
    $finish;
  end

endmodule

>>> chirp_tone_envelope_synth_unit.f
hdl/ctse_pkg.sv
hdl/ctse_div.sv
hdl/ctse_datapath.sv
hdl/ctse_ctrl.sv
hdl/chirp_tone_envelope_synth_unit.sv
hdl/ctse_checker.sv
tb/sv/chirp_tone_envelope_synth_unit_tb.sv
